// ===== sv/dewd_pkg.sv =====
// Shared types and constants for the detector event word decoder.
package dewd_pkg;

  // Width of the configuration write data (widest register)
  localparam int unsigned CfgDataWidth = 32;
  localparam int unsigned CfgIndexWidth = 3;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_NEUTRON = 2'd1,
    KIND_TRIGGER = 2'd2,
    KIND_IGNORED = 2'd3
  } kind_e;

  // Configuration register indexes
  typedef enum logic [CfgIndexWidth-1:0] {
    REG_MON1_DATA_ID = 3'd0,
    REG_MON2_DATA_ID = 3'd1,
    REG_MON1_DEVICE  = 3'd2,
    REG_MON2_DEVICE  = 3'd3,
    REG_LIMIT_MON1   = 3'd4,
    REG_LIMIT_MON2   = 3'd5,
    REG_LIMIT_EVENTS = 3'd6
  } cfg_reg_e;

  // Input mode codes
  localparam logic MODE_HEADER = 1'b0;
  localparam logic MODE_EVENT  = 1'b1;

  // Reset values of the configuration registers
  localparam logic [3:0] Mon1DataIdReset = 4'd0;
  localparam logic [3:0] Mon2DataIdReset = 4'd1;

  typedef struct packed {
    logic        mode;
    logic [7:0]  device_id;
    logic [15:0] buffer_type;
    logic [47:0] header_time;
    logic [15:0] word_low;
    logic [15:0] word_mid;
    logic [15:0] word_high;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [6:0]  channel;
    logic [9:0]  amplitude;
    logic [9:0]  position;
    logic [48:0] timestamp;
    logic [2:0]  trig_id;
    logic [3:0]  data_id;
    logic [20:0] trigger_data;
    logic        accepted;
    logic [31:0] mon1_total;
    logic [31:0] mon2_total;
    logic [31:0] event_total;
  } out_t;

  typedef struct packed {
    logic [3:0]  mon1_data_id;
    logic [3:0]  mon2_data_id;
    logic [7:0]  mon1_device;
    logic [7:0]  mon2_device;
    logic [31:0] limit_mon1;
    logic [31:0] limit_mon2;
    logic [31:0] limit_events;
  } cfg_t;

endpackage

// ===== sv/dewd_cfg.sv =====
// Configuration register file of the detector event word decoder.
module dewd_cfg (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [dewd_pkg::CfgIndexWidth-1:0]     cfg_index_i,
  input  logic [dewd_pkg::CfgDataWidth-1:0]      cfg_wdata_i,
  output dewd_pkg::cfg_t                         cfg_o
);

  dewd_pkg::cfg_t cfg_q, cfg_d;

  // Decode the write onto the addressed register, drop unknown indexes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (dewd_pkg::cfg_reg_e'(cfg_index_i))
        dewd_pkg::REG_MON1_DATA_ID: cfg_d.mon1_data_id = cfg_wdata_i[3:0];
        dewd_pkg::REG_MON2_DATA_ID: cfg_d.mon2_data_id = cfg_wdata_i[3:0];
        dewd_pkg::REG_MON1_DEVICE:  cfg_d.mon1_device  = cfg_wdata_i[7:0];
        dewd_pkg::REG_MON2_DEVICE:  cfg_d.mon2_device  = cfg_wdata_i[7:0];
        dewd_pkg::REG_LIMIT_MON1:   cfg_d.limit_mon1   = cfg_wdata_i[31:0];
        dewd_pkg::REG_LIMIT_MON2:   cfg_d.limit_mon2   = cfg_wdata_i[31:0];
        dewd_pkg::REG_LIMIT_EVENTS: cfg_d.limit_events = cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{mon1_data_id: dewd_pkg::Mon1DataIdReset,
                 mon2_data_id: dewd_pkg::Mon2DataIdReset,
                 mon1_device:  '0,
                 mon2_device:  '0,
                 limit_mon1:   '0,
                 limit_mon2:   '0,
                 limit_events: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/dewd_core.sv =====
// Event decode and buffer/counter state of the detector event word decoder.
module dewd_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dewd_pkg::cfg_t  cfg_i,
  input  dewd_pkg::in_t   item_i,
  input  logic            fire_i,
  output dewd_pkg::out_t  result_o
);

  logic [47:0] base_time_q, base_time_d;
  logic [7:0]  device_q, device_d;
  logic        open_q, open_d;
  logic [31:0] mon1_q, mon1_d;
  logic [31:0] mon2_q, mon2_d;
  logic [31:0] events_q, events_d;

  logic [15:0] w0, w1, w2;
  logic [18:0] offset;
  logic [3:0]  did;
  logic        mon1_hit, mon2_hit, ev_room;

  assign w0 = item_i.word_low;
  assign w1 = item_i.word_mid;
  assign w2 = item_i.word_high;
  assign offset = {w1[2:0], w0};
  assign did = w2[11:8];

  // Count qualifiers: a limit of zero never stops a counter
  assign mon1_hit = (did == cfg_i.mon1_data_id) && (device_q == cfg_i.mon1_device) &&
                    ((cfg_i.limit_mon1 == '0) || (mon1_q < cfg_i.limit_mon1));
  assign mon2_hit = (did == cfg_i.mon2_data_id) && (device_q == cfg_i.mon2_device) &&
                    ((cfg_i.limit_mon2 == '0) || (mon2_q < cfg_i.limit_mon2));
  assign ev_room  = (cfg_i.limit_events == '0) || (events_q < cfg_i.limit_events);

  // Decode one request and work out the next state
  always_comb begin
    base_time_d = base_time_q;
    device_d    = device_q;
    open_d      = open_q;
    mon1_d      = mon1_q;
    mon2_d      = mon2_q;
    events_d    = events_q;
    result_o    = '0;

    if (item_i.mode == dewd_pkg::MODE_HEADER) begin
      base_time_d        = item_i.header_time;
      device_d           = item_i.device_id;
      open_d             = (item_i.buffer_type[15:1] == '0);
      result_o.kind      = dewd_pkg::KIND_HEADER;
      result_o.timestamp = {1'b0, item_i.header_time};
    end else if (!open_q) begin
      result_o.kind = dewd_pkg::KIND_IGNORED;
    end else begin
      result_o.timestamp = {1'b0, base_time_q} + {30'd0, offset};
      if (w2[15]) begin
        result_o.kind         = dewd_pkg::KIND_TRIGGER;
        result_o.trig_id      = w2[14:12];
        result_o.data_id      = did;
        result_o.trigger_data = {w2[7:0], w1[15:3]};
        if (mon1_hit) mon1_d = mon1_q + 32'd1;
        if (mon2_hit) mon2_d = mon2_q + 32'd1;
      end else begin
        result_o.kind      = dewd_pkg::KIND_NEUTRON;
        result_o.channel   = {w2[14:12], w2[10:7]};
        result_o.amplitude = {w2[6:0], w1[15:13]};
        result_o.position  = w1[12:3];
        if (ev_room) begin
          result_o.accepted = 1'b1;
          events_d          = events_q + 32'd1;
        end
      end
    end

    result_o.mon1_total  = mon1_d;
    result_o.mon2_total  = mon2_d;
    result_o.event_total = events_d;
  end

  // Advance the state only when the request moves on to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_time_q <= '0;
      device_q    <= '0;
      open_q      <= 1'b0;
      mon1_q      <= '0;
      mon2_q      <= '0;
      events_q    <= '0;
    end else if (fire_i) begin
      base_time_q <= base_time_d;
      device_q    <= device_d;
      open_q      <= open_d;
      mon1_q      <= mon1_d;
      mon2_q      <= mon2_d;
      events_q    <= events_d;
    end
  end

endmodule

// ===== sv/detector_event_word_decoder.sv =====
// Detector event word decoder: input register, decode core and result register.
//
// Usage: requests arrive on in_valid_i / in_data_i and are taken at a rising
// edge with in_valid_i high and in_stall_o low. A header request latches base
// time, device and buffer type; an event request is decoded into a neutron,
// trigger or ignored result carrying the running monitor and event totals.
// Results leave on out_valid_o / out_data_o and are taken when out_stall_i is
// low. Configuration is written through cfg_we_i, cfg_index_i, cfg_wdata_i
// while the block is idle; unknown indexes are dropped.
// Throughput: one request per cycle while out_stall_i is low, set by the single
// decode stage between the input register and the result register.
// Reset clears both stages, the counters and the buffer state; the buffer
// starts closed so events before a header give ignored results.
// A stalled result holds steady; the input register keeps taking a request
// while the result waits, and in_stall_o rises only when both are full.
module detector_event_word_decoder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  dewd_pkg::in_t                       in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output dewd_pkg::out_t                      out_data_o,
  input  logic                                cfg_we_i,
  input  logic [dewd_pkg::CfgIndexWidth-1:0]  cfg_index_i,
  input  logic [dewd_pkg::CfgDataWidth-1:0]   cfg_wdata_i
);

  dewd_pkg::cfg_t cfg;
  dewd_pkg::in_t  item_q;
  dewd_pkg::out_t result, result_q;
  logic           item_valid_q;
  logic           out_valid_q;
  logic           out_free;
  logic           fire;
  logic           in_take;

  dewd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Handshake: the result register frees when empty or being taken
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = item_valid_q && out_free;
  assign in_stall_o = item_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  dewd_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .item_i   (item_q),
    .fire_i   (fire),
    .result_o (result)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= in_data_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= item_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      result_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = result_q;

  // Input stalls only while both stages hold a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (item_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a full pipeline");

  // A request that fires reaches the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("fired request lost");

  // Only neutron results may carry the accepted flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (result_q.kind != dewd_pkg::KIND_NEUTRON)) |-> !result_q.accepted)
    else $error("accepted flag on a non-neutron result");

  // Non-neutron results leave the event total as it was
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (result.kind != dewd_pkg::KIND_NEUTRON)) |=>
      (result_q.event_total == $past(result_q.event_total) || !$past(out_valid_q)))
    else $error("event total changed by a non-neutron result");

endmodule
